// File: rtl/core/isc_pkg.sv
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types and constants for the interpolated string scanner.
// ----------------------------------------------------------------------------
package isc_pkg;

    // default limits
    localparam int MAX_LENGTH_DEF = 65536;
    localparam int MAX_DEPTH_DEF  = 255;

    // result queue depth
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_RBRACK = 8'h5D;

    // result kinds
    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_EXPR    = 2'd1;
    localparam logic [1:0] KIND_DONE_OK = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // scanner modes
    typedef enum logic [8:0] {
        MODE_LIT       = 9'b000000001,
        MODE_LIT_ESC   = 9'b000000010,
        MODE_BRACE     = 9'b000000100,
        MODE_EXPR      = 9'b000001000,
        MODE_EXPR_ESC  = 9'b000010000,
        MODE_QUOTE     = 9'b000100000,
        MODE_QUOTE_ESC = 9'b001000000,
        MODE_EQ        = 9'b010000000,
        MODE_DRAIN     = 9'b100000000
    } mode_t;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  byte_out;
        logic [15:0] expr_first;
        logic [15:0] expr_past;
        logic [15:0] fmt_first;
        logic [15:0] fmt_close;
        logic        echo_eq;
        logic        fmt_on;
        logic        last_result;
    } result_t;

    localparam int TDATA_W = 80;

endpackage

// File: rtl/core/isc_scan.sv
// ----------------------------------------------------------------------------
// isc_scan
// Scanner state and one-character update; emits up to two results a step.
// ----------------------------------------------------------------------------
module isc_scan #(
    parameter int MAX_LENGTH = isc_pkg::MAX_LENGTH_DEF,
    parameter int MAX_DEPTH  = isc_pkg::MAX_DEPTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        ch,
    input  logic              last,
    output isc_pkg::result_t  res0,
    output isc_pkg::result_t  res1,
    output logic [1:0]        res_count
);
    import isc_pkg::*;

    localparam int POS_W   = $clog2(MAX_LENGTH + 1);
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    mode_t              mode_reg, mode_next, mode_cur;
    logic               quote_single_reg, quote_single_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [15:0]        es_reg, es_next;
    logic [15:0]        ee_reg, ee_next;
    logic [15:0]        ss_reg, ss_next;
    logic [15:0]        eq_pos_reg, eq_pos_next;
    logic               self_reg, self_next;
    logic               spec_reg, spec_next;
    logic               ovf_reg, ovf_next;

    logic               do_expr;
    logic               have0;
    logic               ok;
    logic [15:0]        pos16;
    result_t            r0, r1, fin;

    // single-character state update
    always_comb begin
        mode_next         = mode_reg;
        quote_single_next = quote_single_reg;
        depth_next        = depth_reg;
        es_next           = es_reg;
        ee_next           = ee_reg;
        ss_next           = ss_reg;
        eq_pos_next       = eq_pos_reg;
        self_next         = self_reg;
        spec_next         = spec_reg;
        ovf_next          = ovf_reg;
        do_expr           = 1'b0;
        have0             = 1'b0;
        ok                = 1'b0;
        r0                = '0;
        r1                = '0;
        fin               = '0;
        pos16             = 16'(pos_reg);
        mode_cur          = mode_reg;

        // length overflow
        if (mode_reg != MODE_DRAIN && pos_reg >= POS_W'(MAX_LENGTH)) begin
            ovf_next = 1'b1;
            mode_cur = MODE_DRAIN;
        end
        mode_next = mode_cur;

        unique case (mode_cur)
            MODE_LIT: begin
                if (ch == CH_BSLASH) begin
                    have0       = 1'b1;
                    r0.byte_out = ch;
                    mode_next   = MODE_LIT_ESC;
                end else if (ch == CH_LBRACE) begin
                    mode_next = MODE_BRACE;
                end else begin
                    have0       = 1'b1;
                    r0.byte_out = ch;
                end
            end
            MODE_LIT_ESC: begin
                have0       = 1'b1;
                r0.byte_out = ch;
                mode_next   = MODE_LIT;
            end
            MODE_BRACE: begin
                if (ch == CH_LBRACE) begin
                    have0       = 1'b1;
                    r0.byte_out = CH_LBRACE;
                    mode_next   = MODE_LIT;
                end else begin
                    es_next    = pos16;
                    ee_next    = '0;
                    ss_next    = '0;
                    depth_next = '0;
                    self_next  = 1'b0;
                    spec_next  = 1'b0;
                    mode_next  = MODE_EXPR;
                    do_expr    = 1'b1;
                end
            end
            MODE_EXPR: begin
                do_expr = 1'b1;
            end
            MODE_EXPR_ESC: begin
                mode_next = MODE_EXPR;
            end
            MODE_QUOTE: begin
                if (ch == CH_BSLASH) begin
                    mode_next = MODE_QUOTE_ESC;
                end else if (ch == (quote_single_reg ? CH_SQUOTE : CH_DQUOTE)) begin
                    mode_next = MODE_EXPR;
                end
            end
            MODE_QUOTE_ESC: begin
                mode_next = MODE_QUOTE;
            end
            MODE_EQ: begin
                mode_next = MODE_EXPR;
                if (ch != CH_EQUAL) begin
                    if (!self_reg) begin
                        ee_next   = eq_pos_reg;
                        self_next = 1'b1;
                    end
                    do_expr = 1'b1;
                end
            end
            default: begin
                mode_next = MODE_DRAIN;
            end
        endcase

        // character inside an expression
        if (do_expr) begin
            unique case (ch)
                CH_BSLASH: mode_next = MODE_EXPR_ESC;
                CH_DQUOTE: begin
                    quote_single_next = 1'b0;
                    mode_next         = MODE_QUOTE;
                end
                CH_SQUOTE: begin
                    quote_single_next = 1'b1;
                    mode_next         = MODE_QUOTE;
                end
                CH_LBRACE, CH_LPAREN, CH_LBRACK: begin
                    if (depth_next >= DEPTH_W'(MAX_DEPTH)) begin
                        ovf_next  = 1'b1;
                        mode_next = MODE_DRAIN;
                    end else begin
                        depth_next = depth_next + 1'b1;
                    end
                end
                CH_RPAREN, CH_RBRACK: begin
                    if (depth_next != '0) depth_next = depth_next - 1'b1;
                end
                CH_RBRACE: begin
                    if (depth_next != '0) begin
                        depth_next = depth_next - 1'b1;
                    end else begin
                        if (!self_next && !spec_next) ee_next = pos16;
                        have0         = 1'b1;
                        r0.kind       = KIND_EXPR;
                        r0.expr_first = es_next;
                        r0.expr_past  = ee_next;
                        r0.fmt_first  = spec_next ? ss_next : 16'd0;
                        r0.fmt_close  = spec_next ? pos16 : 16'd0;
                        r0.echo_eq    = self_next;
                        r0.fmt_on     = spec_next;
                        self_next     = 1'b0;
                        spec_next     = 1'b0;
                        mode_next     = MODE_LIT;
                    end
                end
                CH_EQUAL: begin
                    if (depth_next == '0 && !spec_next) begin
                        eq_pos_next = pos16;
                        mode_next   = MODE_EQ;
                    end
                end
                CH_COLON: begin
                    if (depth_next == '0 && !spec_next) begin
                        if (!self_next) ee_next = pos16;
                        spec_next = 1'b1;
                        ss_next   = pos16 + 16'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        // position advances up to the limit
        pos_next = (pos_reg < POS_W'(MAX_LENGTH)) ? pos_reg + 1'b1 : pos_reg;

        // end of string: status result and return to reset state
        if (last) begin
            ok = !ovf_next && (mode_next == MODE_LIT || mode_next == MODE_LIT_ESC);
            fin.kind          = ok ? KIND_DONE_OK : KIND_ERROR;
            fin.last_result   = 1'b1;
            mode_next         = MODE_LIT;
            quote_single_next = 1'b0;
            depth_next        = '0;
            pos_next          = '0;
            es_next           = '0;
            ee_next           = '0;
            ss_next           = '0;
            eq_pos_next       = '0;
            self_next         = 1'b0;
            spec_next         = 1'b0;
            ovf_next          = 1'b0;
            if (have0) begin
                r1 = fin;
            end else begin
                r0 = fin;
            end
        end else begin
            r0.last_result = have0;
        end
    end

    assign res0      = r0;
    assign res1      = r1;
    assign res_count = {1'b0, have0} + {1'b0, last};

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_LIT;
            quote_single_reg <= 1'b0;
            depth_reg        <= '0;
            pos_reg          <= '0;
            es_reg           <= '0;
            ee_reg           <= '0;
            ss_reg           <= '0;
            eq_pos_reg       <= '0;
            self_reg         <= 1'b0;
            spec_reg         <= 1'b0;
            ovf_reg          <= 1'b0;
        end else if (step) begin
            mode_reg         <= mode_next;
            quote_single_reg <= quote_single_next;
            depth_reg        <= depth_next;
            pos_reg          <= pos_next;
            es_reg           <= es_next;
            ee_reg           <= ee_next;
            ss_reg           <= ss_next;
            eq_pos_reg       <= eq_pos_next;
            self_reg         <= self_next;
            spec_reg         <= spec_next;
            ovf_reg          <= ovf_next;
        end
    end

endmodule

// File: rtl/core/isc_res_queue.sv
// ----------------------------------------------------------------------------
// isc_res_queue
// Small result queue that takes up to two results a cycle and gives one when out_ready is high.
// ----------------------------------------------------------------------------
module isc_res_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_count,
    input  isc_pkg::result_t  push0,
    input  isc_pkg::result_t  push1,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output isc_pkg::result_t  out_res
);
    import isc_pkg::*;

    result_t              mem_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0] count_reg, count_next;
    logic [RES_PTR_W-1:0] wr_ptr_1;
    logic                 pop;

    assign room      = count_reg <= RES_CNT_W'(RES_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_res   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign wr_ptr_1  = wr_ptr_reg + 1'b1;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push_count);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + RES_CNT_W'(push_count) - RES_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) mem_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2) mem_reg[wr_ptr_1] <= push1;
    end

endmodule

// File: rtl/core/interpolated_string_scanner_top.sv
// ----------------------------------------------------------------------------
// interpolated_string_scanner_top
// Scans interpolated string characters into literal bytes, expression
// descriptors and a final status result per string.
// ----------------------------------------------------------------------------
// a character waits in the input register, then its results go to the
// result queue, which offers them; throughput: one character per cycle while
// the queue has room; the last character of a string can give two results, the
// queue drains one a cycle while m_tready is high and holds input back at three
// reset: aresetn clears the scanner to literal mode at position zero and
// empties the input register and the result queue
module interpolated_string_scanner_top #(
    parameter int MAX_LENGTH = isc_pkg::MAX_LENGTH_DEF,
    parameter int MAX_DEPTH  = isc_pkg::MAX_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // ch
    input  logic                        s_tlast,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // byte_out, expr_first, expr_past, fmt_first, fmt_close, echo_eq, fmt_on
    output logic [isc_pkg::TDATA_W-1:0] m_tdata,
    output logic [1:0]                  m_tuser,   // kind
    output logic                        m_tlast
);
    import isc_pkg::*;

    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       last_reg;
    logic       room;
    logic       step;
    logic [1:0] res_count;
    logic [1:0] push_count;
    result_t    res0, res1, head;

    assign step       = in_valid_reg && room;
    assign s_tready   = !in_valid_reg || step;
    assign push_count = step ? res_count : 2'd0;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            ch_reg   <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    isc_scan #(
        .MAX_LENGTH (MAX_LENGTH),
        .MAX_DEPTH  (MAX_DEPTH)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .ch        (ch_reg),
        .last      (last_reg),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    isc_res_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (head)
    );

    // result packing
    assign m_tuser = head.kind;
    assign m_tlast = head.last_result;
    assign m_tdata = {6'b0, head.fmt_on, head.echo_eq, head.fmt_close, head.fmt_first,
                      head.expr_past, head.expr_first, head.byte_out};

endmodule
